FILE: rtl/pht_pkg.sv
// Shared types and constants for the Peltier hysteresis thermostat.
`default_nettype none

package pht_pkg;

    localparam int TEMP_WIDTH = 12;
    localparam int SENS_WIDTH = 10;
    // Working width for sign-extended compares: 4*temp - sens fits with margin.
    localparam int EXT_WIDTH  = TEMP_WIDTH + 4;
    localparam int CFG_WIDTH  = (TEMP_WIDTH > SENS_WIDTH) ? TEMP_WIDTH : SENS_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GOAL_TEMP     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SENSITIVITY   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FAN_DIFF_THR  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EQUALIZE_THR  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OVERHEAT_LIM  = 3'd4;

    // Operating mode codes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_HEAT = 2'd1;
    localparam logic [1:0] MODE_COOL = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [TEMP_WIDTH-1:0] GOAL_TEMP_RST    = TEMP_WIDTH'(400);
    localparam logic [SENS_WIDTH-1:0] SENSITIVITY_RST  = SENS_WIDTH'(16);
    localparam logic [TEMP_WIDTH-1:0] FAN_DIFF_THR_RST = TEMP_WIDTH'(160);
    localparam logic [TEMP_WIDTH-1:0] EQUALIZE_THR_RST = TEMP_WIDTH'(16);
    localparam logic [TEMP_WIDTH-1:0] OVERHEAT_LIM_RST = TEMP_WIDTH'(912);

    typedef struct packed {
        logic signed [TEMP_WIDTH-1:0] chamber_temp;
        logic signed [TEMP_WIDTH-1:0] plate_inner_temp;
        logic signed [TEMP_WIDTH-1:0] plate_outer_temp;
        logic                         read_error;
    } sample_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       heat_on;
        logic       cool_on;
        logic       fan_on;
        logic       equalizing_now;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/pht_sample_if.sv
// Valid/ready channel interfaces for sensor samples and control results.
`default_nettype none

interface pht_sample_if;
    logic              valid;
    logic              ready;
    pht_pkg::sample_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pht_result_if;
    logic              valid;
    logic              ready;
    pht_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/peltier_hysteresis_thermostat.sv
// Bang-bang Peltier thermostat with hysteresis, plate equalization and fan control.
//
// Usage:
//   sample (sink): one beat per sensor reading (chamber, inner and outer plate
//   temperatures, read error flag). result (source): one beat per sample with
//   the mode after that sample, relay levels (logical on) and equalizing flag.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//   indexes beyond the overheat limit are ignored. Write only while no sample
//   is in flight.
// Timing:
//   A sample is held in an input register; once the output register is free or
//   being read, the decision logic updates the mode state and loads the result
//   register, which drives result valid. Throughput is one sample per cycle
//   while result.ready keeps the output register draining.
// Stall: while result is held, the input register still takes one beat; then
//   sample.ready drops until result.ready frees the output register.
// Reset: mode idle, not equalizing, pending mode idle, both registers empty,
//   configuration at its documented defaults.
`default_nettype none

module peltier_hysteresis_thermostat (
    input  wire                                 clk,
    input  wire                                 rst_n,
    pht_sample_if.sink                          sample,
    pht_result_if.source                        result,
    input  wire                                 cfg_we,
    input  wire [pht_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  wire [pht_pkg::CFG_WIDTH-1:0]        cfg_data
);

    localparam int TW = pht_pkg::TEMP_WIDTH;
    localparam int EW = pht_pkg::EXT_WIDTH;
    localparam int SW = pht_pkg::SENS_WIDTH;

    // Configuration registers
    logic [TW-1:0] goal_temp_reg;
    logic [SW-1:0] sensitivity_reg;
    logic [TW-1:0] fan_diff_thr_reg;
    logic [TW-1:0] equalize_thr_reg;
    logic [TW-1:0] overheat_lim_reg;

    // Pipeline registers
    logic              in_vld_reg;
    pht_pkg::sample_t  in_data_reg;
    logic              out_vld_reg;
    pht_pkg::result_t  out_data_reg;

    // Control state
    logic [1:0] mode_reg,    mode_next;
    logic       equal_reg,   equal_next;
    logic [1:0] pending_reg, pending_next;
    logic       fan_next;

    logic advance;

    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !in_vld_reg || advance;
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_temp_reg    <= pht_pkg::GOAL_TEMP_RST;
            sensitivity_reg  <= pht_pkg::SENSITIVITY_RST;
            fan_diff_thr_reg <= pht_pkg::FAN_DIFF_THR_RST;
            equalize_thr_reg <= pht_pkg::EQUALIZE_THR_RST;
            overheat_lim_reg <= pht_pkg::OVERHEAT_LIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pht_pkg::REG_GOAL_TEMP:    goal_temp_reg    <= cfg_data[TW-1:0];
                pht_pkg::REG_SENSITIVITY:  sensitivity_reg  <= cfg_data[SW-1:0];
                pht_pkg::REG_FAN_DIFF_THR: fan_diff_thr_reg <= cfg_data[TW-1:0];
                pht_pkg::REG_EQUALIZE_THR: equalize_thr_reg <= cfg_data[TW-1:0];
                pht_pkg::REG_OVERHEAT_LIM: overheat_lim_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Sign-extended operands
    logic signed [EW-1:0] ch_x, pi_x, po_x, goal_x, ovh_x, sens_x;
    logic signed [EW-1:0] diff_x, eq_thr_x, fan_thr_x;
    logic                 plates_close, fan_norm, err;
    logic [1:0]           req;
    logic                 req_ok;

    always_comb
    begin
        ch_x      = EW'(in_data_reg.chamber_temp);
        pi_x      = EW'(in_data_reg.plate_inner_temp);
        po_x      = EW'(in_data_reg.plate_outer_temp);
        goal_x    = EW'($signed(goal_temp_reg));
        ovh_x     = EW'($signed(overheat_lim_reg));
        sens_x    = $signed({{(EW-SW){1'b0}}, sensitivity_reg});
        eq_thr_x  = $signed({{(EW-TW){1'b0}}, equalize_thr_reg});
        fan_thr_x = $signed({{(EW-TW){1'b0}}, fan_diff_thr_reg});
        err       = in_data_reg.read_error;

        diff_x       = (pi_x > po_x) ? (pi_x - po_x) : (po_x - pi_x);
        plates_close = diff_x <= eq_thr_x;
        fan_norm     = (diff_x > fan_thr_x) || (pi_x >= ovh_x) || (po_x >= ovh_x);

        // Hysteresis request; stop points compared in quarter units
        req = mode_reg;
        case (mode_reg)
            pht_pkg::MODE_IDLE:
            begin
                if (ch_x < goal_x - sens_x)
                    req = pht_pkg::MODE_HEAT;
                else if (ch_x > goal_x + sens_x)
                    req = pht_pkg::MODE_COOL;
            end
            pht_pkg::MODE_HEAT:
            begin
                if ((ch_x <<< 2) >= (goal_x <<< 2) - sens_x)
                    req = pht_pkg::MODE_IDLE;
            end
            pht_pkg::MODE_COOL:
            begin
                if ((ch_x <<< 2) <= (goal_x <<< 2) + sens_x)
                    req = pht_pkg::MODE_IDLE;
            end
            default: req = pht_pkg::MODE_IDLE;
        endcase

        req_ok = (req == pht_pkg::MODE_IDLE) ||
                 ((req == pht_pkg::MODE_HEAT) && (pi_x > po_x)) ||
                 ((req == pht_pkg::MODE_COOL) && (pi_x < po_x));

        mode_next    = mode_reg;
        equal_next   = equal_reg;
        pending_next = pending_reg;
        fan_next     = fan_norm;

        if (err)
        begin
            mode_next  = pht_pkg::MODE_IDLE;
            equal_next = 1'b0;
            fan_next   = 1'b0;
        end
        else if (equal_reg)
        begin
            if (plates_close)
            begin
                equal_next = 1'b0;
                mode_next  = pending_reg;
                fan_next   = 1'b0;
            end
            else
            begin
                mode_next = pht_pkg::MODE_IDLE;
                fan_next  = 1'b1;
            end
        end
        else if (req != mode_reg)
        begin
            if (req_ok)
            begin
                mode_next = req;
            end
            else if (plates_close)
            begin
                mode_next = req;
                fan_next  = 1'b0;
            end
            else
            begin
                // Hold idle with the fan on until the plates even out
                mode_next    = pht_pkg::MODE_IDLE;
                equal_next   = 1'b1;
                pending_next = req;
                fan_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mode_reg    <= pht_pkg::MODE_IDLE;
            equal_reg   <= 1'b0;
            pending_reg <= pht_pkg::MODE_IDLE;
        end
        else
        begin
            if (sample.ready)
                in_vld_reg <= sample.valid;
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                mode_reg    <= mode_next;
                equal_reg   <= equal_next;
                pending_reg <= pending_next;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
            in_data_reg <= sample.data;
        if (advance)
        begin
            out_data_reg.mode_now       <= mode_next;
            out_data_reg.heat_on        <= (mode_next == pht_pkg::MODE_HEAT);
            out_data_reg.cool_on        <= (mode_next == pht_pkg::MODE_COOL);
            out_data_reg.fan_on         <= fan_next;
            out_data_reg.equalizing_now <= equal_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/peltier_hysteresis_thermostat_tb.sv
// Self-checking testbench for the Peltier hysteresis thermostat: directed and random samples.

module peltier_hysteresis_thermostat_tb;

    localparam int TW             = pht_pkg::TEMP_WIDTH;
    localparam int SW             = pht_pkg::SENS_WIDTH;
    localparam int IW             = pht_pkg::CFG_IDX_WIDTH;
    localparam int CW             = pht_pkg::CFG_WIDTH;
    localparam int TEMP_CEIL      = (1 << (TW - 1)) - 1;
    localparam int TEMP_FLOOR     = -(1 << (TW - 1));
    localparam int SENS_MAX       = (1 << SW) - 1;
    localparam int THR_MAX        = (1 << TW) - 1;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [IW-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    pht_sample_if sample_ch ();
    pht_result_if result_ch ();

    peltier_hysteresis_thermostat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [TW-1:0] goal_cfg = pht_pkg::GOAL_TEMP_RST;
    logic [SW-1:0] sens_cfg = pht_pkg::SENSITIVITY_RST;
    logic [TW-1:0] fan_thr_cfg = pht_pkg::FAN_DIFF_THR_RST;
    logic [TW-1:0] eq_thr_cfg = pht_pkg::EQUALIZE_THR_RST;
    logic [TW-1:0] overheat_cfg = pht_pkg::OVERHEAT_LIM_RST;

    // Shadow copy of the control state.
    logic [1:0] mode_st = pht_pkg::MODE_IDLE;
    logic [1:0] pending_st = pht_pkg::MODE_IDLE;
    logic       equalizing_st = 1'b0;

    pht_pkg::result_t expected_controls[$];
    pht_pkg::result_t oldest_control;
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      chamber_walk = 400;

    function automatic int rand_int(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic [TW-1:0] to_temp(int v);
        if (v > TEMP_CEIL)
            v = TEMP_CEIL;
        else if (v < TEMP_FLOOR)
            v = TEMP_FLOOR;
        return TW'(v);
    endfunction

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = rand_int(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return rand_int(1, 3);
        else if (roll < 97)
            return rand_int(4, 12);
        return rand_int(13, 40);
    endfunction

    // Advance the shadow state by one sample and return the control outputs.
    function automatic pht_pkg::result_t predict_control(pht_pkg::sample_t s);
        int ch;
        int pi;
        int po;
        int goal;
        int sens;
        int ovh;
        int diff;
        logic plates_close;
        logic fan;
        logic [1:0] want;
        pht_pkg::result_t r;
        ch   = $signed(s.chamber_temp);
        pi   = $signed(s.plate_inner_temp);
        po   = $signed(s.plate_outer_temp);
        goal = $signed(goal_cfg);
        sens = int'(sens_cfg);
        ovh  = $signed(overheat_cfg);
        diff = (pi > po) ? pi - po : po - pi;
        plates_close = diff <= int'(eq_thr_cfg);
        fan = diff > int'(fan_thr_cfg) || pi >= ovh || po >= ovh;
        want = mode_st;

        if (s.read_error)
        begin
            mode_st = pht_pkg::MODE_IDLE;
            equalizing_st = 1'b0;
            fan = 1'b0;
        end
        else if (equalizing_st)
        begin
            mode_st = pht_pkg::MODE_IDLE;
            if (plates_close)
            begin
                equalizing_st = 1'b0;
                mode_st = pending_st;
                fan = 1'b0;
            end
            else
            begin
                fan = 1'b1;
            end
        end
        else
        begin
            case (mode_st)
                pht_pkg::MODE_IDLE:
                begin
                    if (ch < goal - sens)
                        want = pht_pkg::MODE_HEAT;
                    else if (ch > goal + sens)
                        want = pht_pkg::MODE_COOL;
                end
                // Stop points sit a quarter band inside the goal, compared at 4x scale.
                pht_pkg::MODE_HEAT:
                begin
                    if (4 * ch >= 4 * goal - sens)
                        want = pht_pkg::MODE_IDLE;
                end
                pht_pkg::MODE_COOL:
                begin
                    if (4 * ch <= 4 * goal + sens)
                        want = pht_pkg::MODE_IDLE;
                end
                default:
                begin
                    want = pht_pkg::MODE_IDLE;
                end
            endcase
            if (want != mode_st)
            begin
                if (want == pht_pkg::MODE_IDLE ||
                    (want == pht_pkg::MODE_HEAT && pi > po) ||
                    (want == pht_pkg::MODE_COOL && pi < po))
                begin
                    mode_st = want;
                end
                else if (plates_close)
                begin
                    mode_st = want;
                    fan = 1'b0;
                end
                else
                begin
                    mode_st = pht_pkg::MODE_IDLE;
                    equalizing_st = 1'b1;
                    pending_st = want;
                    fan = 1'b1;
                end
            end
        end

        r.mode_now = mode_st;
        r.heat_on = (mode_st == pht_pkg::MODE_HEAT);
        r.cool_on = (mode_st == pht_pkg::MODE_COOL);
        r.fan_on = fan;
        r.equalizing_now = equalizing_st;
        return r;
    endfunction

    // Send one sample beat; valid stays high on return, so callers that stop drop it.
    task automatic send_sample(pht_pkg::sample_t s, int gap);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= s;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        expected_controls.push_back(predict_control(s));
    endtask

    task automatic send_fields(int ch, int pi, int po, bit err);
        pht_pkg::sample_t s;
        s.chamber_temp = to_temp(ch);
        s.plate_inner_temp = to_temp(pi);
        s.plate_outer_temp = to_temp(po);
        s.read_error = err;
        send_sample(s, pick_gap());
    endtask

    // Hold off the sender until every expected beat has come back.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (expected_controls.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [IW-1:0] index, logic [CW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            pht_pkg::REG_GOAL_TEMP:    goal_cfg = value[TW-1:0];
            pht_pkg::REG_SENSITIVITY:  sens_cfg = value[SW-1:0];
            pht_pkg::REG_FAN_DIFF_THR: fan_thr_cfg = value[TW-1:0];
            pht_pkg::REG_EQUALIZE_THR: eq_thr_cfg = value[TW-1:0];
            pht_pkg::REG_OVERHEAT_LIM: overheat_cfg = value[TW-1:0];
            default:                   ;
        endcase
    endtask

    task automatic apply_settings(int goal, int sens, int fan_thr, int eq_thr, int ovh);
        int idx;
        drain_results();
        write_register(pht_pkg::REG_GOAL_TEMP, CW'(goal));
        // Upper data bits above the sensitivity field carry junk.
        write_register(pht_pkg::REG_SENSITIVITY, CW'({$urandom, SW'(sens)}));
        write_register(pht_pkg::REG_FAN_DIFF_THR, CW'(fan_thr));
        write_register(pht_pkg::REG_EQUALIZE_THR, CW'(eq_thr));
        write_register(pht_pkg::REG_OVERHEAT_LIM, CW'(ovh));
        for (idx = int'(pht_pkg::REG_OVERHEAT_LIM) + 1; idx < (1 << IW); idx++)
            write_register(IW'(idx), CW'($urandom));
        cfg_we <= 1'b0;
        chamber_walk = goal;
    endtask

    // Samples that ride the hysteresis band, with noise and sensor faults mixed in.
    task automatic run_random_samples(int count, bit gaps_on);
        int i;
        int goal;
        int sens;
        int step;
        int base;
        int d;
        logic [63:0] raw;
        pht_pkg::sample_t s;
        for (i = 0; i < count; i++)
        begin
            goal = $signed(goal_cfg);
            sens = int'(sens_cfg);
            step = sens / 4 + 2;
            if (rand_int(0, 99) < 8)
            begin
                raw = {$urandom, $urandom};
                s = raw[$bits(pht_pkg::sample_t)-1:0];
            end
            else
            begin
                case (rand_int(0, 9))
                    0, 1:
                    begin
                        case (rand_int(0, 5))
                            0: chamber_walk = goal - sens - 1 - rand_int(0, 3);
                            1: chamber_walk = goal - sens;
                            2: chamber_walk = goal - sens / 4 + rand_int(-1, 1);
                            3: chamber_walk = goal + sens / 4 + rand_int(-1, 1);
                            4: chamber_walk = goal + sens;
                            default: chamber_walk = goal + sens + 1 + rand_int(0, 3);
                        endcase
                    end
                    2:
                        chamber_walk = rand_int(TEMP_FLOOR, TEMP_CEIL);
                    default:
                        chamber_walk = chamber_walk + rand_int(-step, step);
                endcase
                chamber_walk = $signed(to_temp(chamber_walk));

                if (rand_int(0, 99) < 15)
                    base = $signed(overheat_cfg) + rand_int(-2, 1);
                else
                    base = chamber_walk + rand_int(-64, 64);
                case (rand_int(0, 6))
                    0: d = 0;
                    1: d = int'(eq_thr_cfg);
                    2: d = int'(eq_thr_cfg) + 1;
                    3: d = int'(fan_thr_cfg);
                    4: d = int'(fan_thr_cfg) + 1;
                    5: d = rand_int(0, int'(eq_thr_cfg) + 40);
                    default: d = rand_int(0, THR_MAX);
                endcase
                if (rand_int(0, 1) == 0)
                    d = -d;
                s.chamber_temp = to_temp(chamber_walk);
                s.plate_inner_temp = to_temp(base);
                s.plate_outer_temp = to_temp(base + d);
                s.read_error = (rand_int(0, 99) < 4);
            end
            send_sample(s, gaps_on ? pick_gap() : 0);
            if (i == count / 2 && rand_int(0, 2) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Band edges, equalizing, sensor faults and field extremes under reset settings.
    task automatic test_hysteresis_directed();
        send_fields(400, 100, 100, 1'b0);
        send_fields(384, 100, 100, 1'b0);
        send_fields(383, 200, 100, 1'b0);
        send_fields(395, 200, 100, 1'b0);
        send_fields(396, 200, 100, 1'b0);
        send_fields(417, 100, 200, 1'b0);
        send_fields(405, 100, 200, 1'b0);
        send_fields(404, 100, 200, 1'b0);
        send_fields(383, 100, 200, 1'b0);
        send_fields(383, 150, 180, 1'b0);
        send_fields(383, 170, 186, 1'b0);
        send_fields(396, 170, 186, 1'b0);
        send_fields(383, 100, 110, 1'b0);
        send_fields(400, 100, 110, 1'b0);
        send_fields(417, 300, 100, 1'b0);
        send_fields(417, 300, 100, 1'b1);
        send_fields(400, 900, 912, 1'b0);
        send_fields(400, 0, 161, 1'b0);
        send_fields(400, 0, 160, 1'b0);
        send_fields(TEMP_FLOOR, TEMP_CEIL, TEMP_FLOOR, 1'b0);
        send_fields(TEMP_CEIL, TEMP_FLOOR, TEMP_CEIL, 1'b0);
        send_fields(TEMP_CEIL, TEMP_FLOOR, TEMP_CEIL, 1'b0);
        send_fields(TEMP_CEIL, TEMP_FLOOR, TEMP_CEIL, 1'b1);
        drain_results();
    endtask

    task automatic test_extreme_settings();
        apply_settings(TEMP_FLOOR, 0, 0, 0, TEMP_FLOOR);
        run_random_samples(60, 1'b1);
        apply_settings(TEMP_CEIL, SENS_MAX, THR_MAX, THR_MAX, TEMP_CEIL);
        run_random_samples(60, 1'b0);
    endtask

    task automatic test_random_settings();
        int phase;
        int goal;
        int sens;
        int fan_thr;
        int eq_thr;
        int ovh;
        for (phase = 0; phase < 6; phase++)
        begin
            goal    = (rand_int(0, 9) < 7) ? rand_int(-600, 600)
                                           : rand_int(TEMP_FLOOR, TEMP_CEIL);
            sens    = (rand_int(0, 9) < 7) ? rand_int(0, 64) : rand_int(0, SENS_MAX);
            fan_thr = (rand_int(0, 9) < 7) ? rand_int(0, 400) : rand_int(0, THR_MAX);
            eq_thr  = (rand_int(0, 9) < 7) ? rand_int(0, 64) : rand_int(0, THR_MAX);
            ovh     = (rand_int(0, 9) < 7) ? rand_int(700, 1000)
                                           : rand_int(TEMP_FLOOR, TEMP_CEIL);
            apply_settings(goal, sens, fan_thr, eq_thr, ovh);
            run_random_samples(64, rand_int(0, 3) != 0);
        end
    endtask

    // Result sink: bursts of ready with random stalls between them.
    initial
    begin
        int burst;
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            burst = (rand_int(0, 9) == 0) ? rand_int(50, 150) : rand_int(1, 20);
            repeat (burst) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_controls.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with none expected, actual %h",
                         $time, result_ch.data);
            end
            else
            begin
                oldest_control = expected_controls.pop_front();
                check_field("mode_now", int'(oldest_control.mode_now),
                            int'(result_ch.data.mode_now));
                check_field("heat_on", int'(oldest_control.heat_on),
                            int'(result_ch.data.heat_on));
                check_field("cool_on", int'(oldest_control.cool_on),
                            int'(result_ch.data.cool_on));
                check_field("fan_on", int'(oldest_control.fan_on),
                            int'(result_ch.data.fan_on));
                check_field("equalizing_now", int'(oldest_control.equalizing_now),
                            int'(result_ch.data.equalizing_now));
            end
        end
    end

    // Abort when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= pht_pkg::REG_GOAL_TEMP;
        cfg_data <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hysteresis_directed();
        test_extreme_settings();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
